/* src/lexical_token_scanner_unit_assert.svh */
// Assertion macros shared by the scanner RTL.
`ifndef LEXICAL_TOKEN_SCANNER_UNIT_ASSERT_SVH
`define LEXICAL_TOKEN_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lts_pkg.sv */
package lts_pkg;

    localparam int MAX_TOKEN_LEN_DEF  = 32;
    localparam int VALUE_WIDTH_DEF    = 32;
    localparam int POSITION_WIDTH_DEF = 16;

    localparam int CHAR_W   = 8;
    localparam int CODE_W   = 5;
    localparam int VALUE_W  = 32;
    localparam int LEN_W    = 6;
    localparam int START_W  = 16;
    localparam int KW_N     = 6;
    localparam int KW_IDX_W = 3;
    localparam int TDATA_W  = 64;
    localparam int TUSER_W  = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [CODE_W-1:0] TC_END        = 5'd0;
    localparam logic [CODE_W-1:0] TC_FOR        = 5'd1;
    localparam logic [CODE_W-1:0] TC_IDENT      = 5'd10;
    localparam logic [CODE_W-1:0] TC_NUMBER     = 5'd11;
    localparam logic [CODE_W-1:0] TC_PLUS       = 5'd13;
    localparam logic [CODE_W-1:0] TC_MINUS      = 5'd14;
    localparam logic [CODE_W-1:0] TC_STAR       = 5'd15;
    localparam logic [CODE_W-1:0] TC_SLASH      = 5'd16;
    localparam logic [CODE_W-1:0] TC_COLON      = 5'd17;
    localparam logic [CODE_W-1:0] TC_ASSIGN     = 5'd18;
    localparam logic [CODE_W-1:0] TC_LESS       = 5'd20;
    localparam logic [CODE_W-1:0] TC_NOT_EQ     = 5'd21;
    localparam logic [CODE_W-1:0] TC_LESS_EQ    = 5'd22;
    localparam logic [CODE_W-1:0] TC_GREATER    = 5'd23;
    localparam logic [CODE_W-1:0] TC_GREATER_EQ = 5'd24;
    localparam logic [CODE_W-1:0] TC_EQUAL      = 5'd25;
    localparam logic [CODE_W-1:0] TC_SEMI       = 5'd26;
    localparam logic [CODE_W-1:0] TC_LPAREN     = 5'd27;
    localparam logic [CODE_W-1:0] TC_RPAREN     = 5'd28;

    localparam logic [KW_N-1:0] KW_ALL = 6'h3F;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic               err;
        logic [VALUE_W-1:0] value;
        logic               ovf;
        logic [LEN_W-1:0]   len;
        logic [START_W-1:0] start;
        logic               eot;
        logic               last;
    } t_token;

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [KW_IDX_W-1:0] kw_len(input int k);
        logic [KW_IDX_W-1:0] r;
        unique case (k)
            0:       r = 3'd3;
            1:       r = 3'd2;
            2:       r = 3'd4;
            3:       r = 3'd4;
            4:       r = 3'd5;
            default: r = 3'd2;
        endcase
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] kw_char(input int k, input logic [KW_IDX_W-1:0] idx);
        logic [8*KW_N-1:0] s;
        unique case (k)
            0:       s = {"for", 24'h0};
            1:       s = {"if", 32'h0};
            2:       s = {"then", 16'h0};
            3:       s = {"else", 16'h0};
            4:       s = {"while", 8'h0};
            default: s = {"do", 32'h0};
        endcase
        return s[8*KW_N-1 - 8*idx -: 8];
    endfunction

    function automatic logic [KW_N-1:0] kw_update(input logic [KW_N-1:0] match,
                                                  input logic [KW_IDX_W-1:0] idx,
                                                  input logic [CHAR_W-1:0] c);
        logic [KW_N-1:0] r;
        for (int k = 0; k < KW_N; k++) begin
            r[k] = match[k] && (idx < kw_len(k)) && (kw_char(k, idx) == c);
        end
        return r;
    endfunction

endpackage

/* src/lexical_token_scanner_unit.sv */
// Streaming lexer: one ASCII character per input beat, tokens out as beats. It accepts one
// character every cycle; each character yields zero, one or two result beats, which wait in a
// four-entry result queue, and the input is held off only while that queue has fewer than two
// free entries, so the sustained rate is one character per cycle as long as the output side
// takes on average one beat per character. Results: keywords (for, if, then, else, while, do),
// letter-only identifiers, saturating decimal numbers, single and two-character operators
// (:= <> <= >=), error beats for unknown characters and digits followed by a letter, and an
// end beat on '#', which also returns the scanner and its position counter to reset state.
// tlast marks the final result beat caused by one character.
`include "lexical_token_scanner_unit_assert.svh"

module lexical_token_scanner_unit #(
    parameter int MAX_TOKEN_LEN  = lts_pkg::MAX_TOKEN_LEN_DEF,
    parameter int VALUE_WIDTH    = lts_pkg::VALUE_WIDTH_DEF,
    parameter int POSITION_WIDTH = lts_pkg::POSITION_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [lts_pkg::CHAR_W-1:0]  i_s_tdata,   // [7:0] char_in
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [4:0] token_code, [36:5] number_value, [37] overflow_flag, [43:38] token_length,
    // [59:44] token_start, [63:60] zero
    output logic [lts_pkg::TDATA_W-1:0] o_m_tdata,
    output logic [lts_pkg::TUSER_W-1:0] o_m_tuser,   // [0] is_error, [1] end_of_text
    output logic                        o_m_tlast    // last_of_run
);

    localparam int VXW = (VALUE_WIDTH > lts_pkg::VALUE_W) ? VALUE_WIDTH : lts_pkg::VALUE_W;
    localparam int SXW = (POSITION_WIDTH > lts_pkg::START_W) ? POSITION_WIDTH
                                                              : lts_pkg::START_W;
    localparam int MW  = VALUE_WIDTH + 4;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_COLON,
        MODE_LESS,
        MODE_GREATER
    } t_mode;

    t_mode                             r_mode, n_mode;
    logic [lts_pkg::KW_N-1:0]          r_kw, n_kw;
    logic [lts_pkg::LEN_W-1:0]         r_len, n_len;
    logic [VALUE_WIDTH-1:0]            r_acc, n_acc;
    logic                              r_sat, n_sat;
    logic [POSITION_WIDTH-1:0]         r_pos, n_pos;
    logic [POSITION_WIDTH-1:0]         r_start, n_start;

    lts_pkg::t_token                   r_fifo [lts_pkg::FIFO_DEPTH];
    logic [lts_pkg::FIFO_PTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [lts_pkg::FIFO_CNT_W-1:0]    r_count;

    logic [lts_pkg::CHAR_W-1:0]        w_c;
    logic                              w_in_acc, w_pop;
    logic [1:0]                        w_cnt;
    lts_pkg::t_token                   w_res0, w_res1, w_tok_a, w_tok_b, w_head;
    logic                              w_emit_a, w_emit_b, w_done, w_reset;
    logic                              w_start;
    t_mode                             w_start_mode;
    logic [MW-1:0]                     w_mul;
    logic [lts_pkg::CODE_W-1:0]        w_id_code;

    function automatic lts_pkg::t_token make_tok(
        input logic [lts_pkg::CODE_W-1:0] code,
        input logic                       err,
        input logic [VALUE_WIDTH-1:0]     val,
        input logic                       ovf,
        input logic [lts_pkg::LEN_W-1:0]  len,
        input logic [POSITION_WIDTH-1:0]  start,
        input logic                       eot
    );
        lts_pkg::t_token t;
        logic [VXW-1:0]  v;
        logic [SXW-1:0]  s;
        v       = VXW'(val);
        s       = SXW'(start);
        t.code  = code;
        t.err   = err;
        t.value = v[lts_pkg::VALUE_W-1:0];
        t.ovf   = ovf;
        t.len   = len;
        t.start = s[lts_pkg::START_W-1:0];
        t.eot   = eot;
        t.last  = 1'b0;
        return t;
    endfunction

    assign w_c        = i_s_tdata;
    assign o_s_tready = r_count < lts_pkg::FIFO_CNT_W'(lts_pkg::FIFO_DEPTH - 1);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_head     = r_fifo[r_rd_ptr];
    assign o_m_tvalid = r_count != '0;
    assign w_pop      = o_m_tvalid && i_m_tready;
    assign o_m_tdata  = {4'b0, w_head.start, w_head.len, w_head.ovf, w_head.value, w_head.code};
    assign o_m_tuser  = {w_head.eot, w_head.err};
    assign o_m_tlast  = w_head.last;

    assign w_mul = (MW'(r_acc) << 3) + (MW'(r_acc) << 1) + MW'(w_c[3:0]);

    always_comb begin
        w_id_code = lts_pkg::TC_IDENT;
        for (int k = lts_pkg::KW_N - 1; k >= 0; k--) begin
            if (!r_sat && r_kw[k] && r_len == lts_pkg::LEN_W'(lts_pkg::kw_len(k))) begin
                w_id_code = lts_pkg::TC_FOR + lts_pkg::CODE_W'(k);
            end
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_kw         = r_kw;
        n_len        = r_len;
        n_acc        = r_acc;
        n_sat        = r_sat;
        n_start      = r_start;
        n_pos        = r_pos + 1'b1;
        w_done       = 1'b0;
        w_reset      = 1'b0;
        w_emit_a     = 1'b0;
        w_emit_b     = 1'b0;
        w_start      = 1'b0;
        w_start_mode = MODE_IDLE;
        w_tok_a      = '0;
        w_tok_b      = '0;

        unique case (r_mode)
            MODE_IDENT: begin
                if (lts_pkg::is_letter(w_c)) begin
                    n_kw = (r_len < lts_pkg::LEN_W'(lts_pkg::KW_N))
                         ? lts_pkg::kw_update(r_kw, r_len[lts_pkg::KW_IDX_W-1:0], w_c) : '0;
                    if (r_len < lts_pkg::LEN_W'(MAX_TOKEN_LEN)) n_len = r_len + 1'b1;
                    else n_sat = 1'b1;
                    w_done = 1'b1;
                end else begin
                    w_emit_a = 1'b1;
                    w_tok_a  = make_tok(w_id_code, 1'b0, '0, r_sat, r_len, r_start, 1'b0);
                end
            end
            MODE_NUMBER: begin
                if (lts_pkg::is_digit(w_c)) begin
                    if (w_mul[MW-1 -: 4] != 4'b0) begin
                        n_acc = '1;
                        n_sat = 1'b1;
                    end else begin
                        n_acc = w_mul[VALUE_WIDTH-1:0];
                    end
                    if (r_len < lts_pkg::LEN_W'(MAX_TOKEN_LEN)) n_len = r_len + 1'b1;
                    else n_sat = 1'b1;
                    w_done = 1'b1;
                end else if (lts_pkg::is_letter(w_c)) begin
                    w_emit_a     = 1'b1;
                    w_tok_a      = make_tok(lts_pkg::TC_NUMBER, 1'b1, '0, r_sat, r_len,
                                            r_start, 1'b0);
                    w_start      = 1'b1;
                    w_start_mode = MODE_IDENT;
                    w_done       = 1'b1;
                end else begin
                    w_emit_a = 1'b1;
                    w_tok_a  = make_tok(lts_pkg::TC_NUMBER, 1'b0, r_acc, r_sat, r_len,
                                        r_start, 1'b0);
                end
            end
            MODE_COLON: begin
                w_emit_a = 1'b1;
                if (w_c == "=") begin
                    w_tok_a = make_tok(lts_pkg::TC_ASSIGN, 1'b0, '0, 1'b0, 6'd2, r_start, 1'b0);
                    n_mode  = MODE_IDLE;
                    w_done  = 1'b1;
                end else begin
                    w_tok_a = make_tok(lts_pkg::TC_COLON, 1'b0, '0, 1'b0, 6'd1, r_start, 1'b0);
                end
            end
            MODE_LESS: begin
                w_emit_a = 1'b1;
                if (w_c == ">") begin
                    w_tok_a = make_tok(lts_pkg::TC_NOT_EQ, 1'b0, '0, 1'b0, 6'd2, r_start, 1'b0);
                    n_mode  = MODE_IDLE;
                    w_done  = 1'b1;
                end else if (w_c == "=") begin
                    w_tok_a = make_tok(lts_pkg::TC_LESS_EQ, 1'b0, '0, 1'b0, 6'd2, r_start,
                                       1'b0);
                    n_mode  = MODE_IDLE;
                    w_done  = 1'b1;
                end else begin
                    w_tok_a = make_tok(lts_pkg::TC_LESS, 1'b0, '0, 1'b0, 6'd1, r_start, 1'b0);
                end
            end
            MODE_GREATER: begin
                w_emit_a = 1'b1;
                if (w_c == "=") begin
                    w_tok_a = make_tok(lts_pkg::TC_GREATER_EQ, 1'b0, '0, 1'b0, 6'd2, r_start,
                                       1'b0);
                    n_mode  = MODE_IDLE;
                    w_done  = 1'b1;
                end else begin
                    w_tok_a = make_tok(lts_pkg::TC_GREATER, 1'b0, '0, 1'b0, 6'd1, r_start,
                                       1'b0);
                end
            end
            default: begin
            end
        endcase

        if (!w_done) begin
            n_mode = MODE_IDLE;
            if (w_c == " " || w_c == "\n") begin
                n_mode = MODE_IDLE;
            end else if (lts_pkg::is_letter(w_c)) begin
                w_start      = 1'b1;
                w_start_mode = MODE_IDENT;
            end else if (lts_pkg::is_digit(w_c)) begin
                w_start      = 1'b1;
                w_start_mode = MODE_NUMBER;
            end else begin
                w_emit_b = 1'b1;
                unique case (w_c)
                    "+": w_tok_b = make_tok(lts_pkg::TC_PLUS, 1'b0, '0, 1'b0, 6'd1, r_pos, 1'b0);
                    "-": w_tok_b = make_tok(lts_pkg::TC_MINUS, 1'b0, '0, 1'b0, 6'd1, r_pos,
                                            1'b0);
                    "*": w_tok_b = make_tok(lts_pkg::TC_STAR, 1'b0, '0, 1'b0, 6'd1, r_pos, 1'b0);
                    "/": w_tok_b = make_tok(lts_pkg::TC_SLASH, 1'b0, '0, 1'b0, 6'd1, r_pos,
                                            1'b0);
                    "=": w_tok_b = make_tok(lts_pkg::TC_EQUAL, 1'b0, '0, 1'b0, 6'd1, r_pos,
                                            1'b0);
                    ";": w_tok_b = make_tok(lts_pkg::TC_SEMI, 1'b0, '0, 1'b0, 6'd1, r_pos, 1'b0);
                    "(": w_tok_b = make_tok(lts_pkg::TC_LPAREN, 1'b0, '0, 1'b0, 6'd1, r_pos,
                                            1'b0);
                    ")": w_tok_b = make_tok(lts_pkg::TC_RPAREN, 1'b0, '0, 1'b0, 6'd1, r_pos,
                                            1'b0);
                    ":": begin
                        w_emit_b     = 1'b0;
                        w_start      = 1'b1;
                        w_start_mode = MODE_COLON;
                    end
                    "<": begin
                        w_emit_b     = 1'b0;
                        w_start      = 1'b1;
                        w_start_mode = MODE_LESS;
                    end
                    ">": begin
                        w_emit_b     = 1'b0;
                        w_start      = 1'b1;
                        w_start_mode = MODE_GREATER;
                    end
                    "#": begin
                        w_tok_b = make_tok(lts_pkg::TC_END, 1'b0, '0, 1'b0, 6'd1, r_pos, 1'b1);
                        w_reset = 1'b1;
                    end
                    default: begin
                        w_tok_b = make_tok(lts_pkg::TC_END, 1'b1, '0, 1'b0, 6'd1, r_pos, 1'b0);
                    end
                endcase
            end
        end

        if (w_start) begin
            n_mode  = w_start_mode;
            n_len   = lts_pkg::LEN_W'(1);
            n_sat   = 1'b0;
            n_start = r_pos;
            n_acc   = lts_pkg::is_digit(w_c) ? VALUE_WIDTH'(w_c[3:0]) : '0;
            n_kw    = lts_pkg::is_letter(w_c)
                    ? lts_pkg::kw_update(lts_pkg::KW_ALL, '0, w_c) : lts_pkg::KW_ALL;
        end

        if (w_reset) begin
            n_mode  = MODE_IDLE;
            n_kw    = lts_pkg::KW_ALL;
            n_len   = '0;
            n_acc   = '0;
            n_sat   = 1'b0;
            n_pos   = '0;
            n_start = '0;
        end
    end

    // Pack the results of this character into queue order and flag the final one.
    always_comb begin
        w_res0 = w_emit_a ? w_tok_a : w_tok_b;
        w_res1 = w_tok_b;
        w_cnt  = 2'(w_emit_a) + 2'(w_emit_b);
        if (w_cnt == 2'd1) w_res0.last = 1'b1;
        if (w_cnt == 2'd2) w_res1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_kw     <= lts_pkg::KW_ALL;
            r_len    <= '0;
            r_acc    <= '0;
            r_sat    <= 1'b0;
            r_pos    <= '0;
            r_start  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_in_acc) begin
                r_mode   <= n_mode;
                r_kw     <= n_kw;
                r_len    <= n_len;
                r_acc    <= n_acc;
                r_sat    <= n_sat;
                r_pos    <= n_pos;
                r_start  <= n_start;
                r_wr_ptr <= r_wr_ptr + lts_pkg::FIFO_PTR_W'(w_cnt);
            end
            if (w_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (w_in_acc ? lts_pkg::FIFO_CNT_W'(w_cnt) : '0)
                     - lts_pkg::FIFO_CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_cnt != 2'd0) r_fifo[r_wr_ptr] <= w_res0;
        if (w_in_acc && w_cnt == 2'd2) r_fifo[r_wr_ptr + 1'b1] <= w_res1;
    end

    `LTS_ASSERT_NOW(a_queue_bound, i_clk, i_rst_n, 1'b1,
        r_count <= lts_pkg::FIFO_CNT_W'(lts_pkg::FIFO_DEPTH), "result queue overfilled")
    `LTS_ASSERT_NOW(a_end_is_last, i_clk, i_rst_n, o_m_tvalid && w_head.eot,
        w_head.last, "end beat not marked last")
    `LTS_ASSERT_NEXT(a_hash_resets, i_clk, i_rst_n, w_in_acc && w_c == "#",
        r_pos == '0 && r_mode == MODE_IDLE, "end character did not reset scanner")
    `LTS_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, w_in_acc && w_cnt != 2'd0,
        o_m_tvalid, "accepted result not presented")

endmodule

/* bench/lexical_token_scanner_checker.sv */
module lexical_token_scanner_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [lts_pkg::CHAR_W-1:0]  i_s_tdata,   // [7:0] char_in
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    // [4:0] token_code, [36:5] number_value, [37] overflow_flag, [43:38] token_length,
    // [59:44] token_start, [63:60] zero
    input  logic [lts_pkg::TDATA_W-1:0] i_m_tdata,
    input  logic [lts_pkg::TUSER_W-1:0] i_m_tuser,   // [0] is_error, [1] end_of_text
    input  logic                        i_m_tlast,   // last_of_run
    output int                          o_fail_count,
    output int                          o_tokens_pending,
    output int                          o_tokens_checked
);
    import lts_pkg::*;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_NUMBER,
        SCAN_COLON,
        SCAN_LESS,
        SCAN_GREATER
    } t_scan_mode;

    localparam longint unsigned NUM_MAX = 64'hFFFF_FFFF;
    localparam int TOKEN_CAP = MAX_TOKEN_LEN_DEF;
    localparam int KW_SPAN   = 6;

    string keyword_text[KW_N] = '{"for", "if", "then", "else", "while", "do"};

    t_scan_mode         mode;
    logic [KW_N-1:0]    kw_hits;
    logic [LEN_W-1:0]   tok_len;
    logic [VALUE_W-1:0] num_acc;
    logic               sat;
    logic [START_W-1:0] char_pos;
    logic [START_W-1:0] tok_start;

    t_token token_beats[$];
    t_token expected_tokens[$];
    int     fails;
    int     checked;

    function automatic logic is_alpha(logic [CHAR_W-1:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_numeral(logic [CHAR_W-1:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic [KW_N-1:0] kw_advance(logic [KW_N-1:0] match, int idx,
                                                   logic [CHAR_W-1:0] c);
        logic [KW_N-1:0] r;
        r = '0;
        for (int k = 0; k < KW_N; k++) begin
            if (match[k] && idx < keyword_text[k].len() && keyword_text[k][idx] == c)
                r[k] = 1'b1;
        end
        return r;
    endfunction

    function automatic void add_token(logic [CODE_W-1:0] code, logic err,
                                      logic [VALUE_W-1:0] value, logic ovf,
                                      logic [LEN_W-1:0] len, logic [START_W-1:0] start,
                                      logic eot);
        t_token t;
        t.code  = code;
        t.err   = err;
        t.value = value;
        t.ovf   = ovf;
        t.len   = len;
        t.start = start;
        t.eot   = eot;
        t.last  = 1'b0;
        token_beats.push_back(t);
    endfunction

    function automatic void clear_scan();
        mode      = SCAN_IDLE;
        kw_hits   = KW_ALL;
        tok_len   = '0;
        num_acc   = '0;
        sat       = 1'b0;
        char_pos  = '0;
        tok_start = '0;
    endfunction

    function automatic void begin_token(t_scan_mode m, logic [CHAR_W-1:0] c,
                                        logic [START_W-1:0] pos);
        mode      = m;
        tok_len   = 1;
        sat       = 1'b0;
        tok_start = pos;
        num_acc   = is_numeral(c) ? VALUE_W'(c - "0") : '0;
        kw_hits   = is_alpha(c) ? kw_advance(KW_ALL, 0, c) : KW_ALL;
    endfunction

    function automatic void lengthen();
        if (tok_len < TOKEN_CAP) tok_len++;
        else sat = 1'b1;
    endfunction

    function automatic void close_ident();
        logic [CODE_W-1:0] code;
        code = TC_IDENT;
        if (!sat) begin
            for (int k = KW_N - 1; k >= 0; k--) begin
                if (kw_hits[k] && tok_len == keyword_text[k].len()) code = TC_FOR + CODE_W'(k);
            end
        end
        add_token(code, 1'b0, '0, sat, tok_len, tok_start, 1'b0);
    endfunction

    function automatic logic fresh_char(logic [CHAR_W-1:0] c, logic [START_W-1:0] pos);
        logic [CODE_W-1:0] code;
        mode = SCAN_IDLE;
        if (c == " " || c == 8'h0A) return 1'b0;
        if (is_alpha(c)) begin
            begin_token(SCAN_IDENT, c, pos);
            return 1'b0;
        end
        if (is_numeral(c)) begin
            begin_token(SCAN_NUMBER, c, pos);
            return 1'b0;
        end
        case (c)
            "+": code = TC_PLUS;
            "-": code = TC_MINUS;
            "*": code = TC_STAR;
            "/": code = TC_SLASH;
            "=": code = TC_EQUAL;
            ";": code = TC_SEMI;
            "(": code = TC_LPAREN;
            ")": code = TC_RPAREN;
            ":": begin
                begin_token(SCAN_COLON, c, pos);
                return 1'b0;
            end
            "<": begin
                begin_token(SCAN_LESS, c, pos);
                return 1'b0;
            end
            ">": begin
                begin_token(SCAN_GREATER, c, pos);
                return 1'b0;
            end
            "#": begin
                add_token(TC_END, 1'b0, '0, 1'b0, 1, pos, 1'b1);
                clear_scan();
                return 1'b1;
            end
            default: begin
                add_token(TC_END, 1'b1, '0, 1'b0, 1, pos, 1'b0);
                return 1'b0;
            end
        endcase
        add_token(code, 1'b0, '0, 1'b0, 1, pos, 1'b0);
        return 1'b0;
    endfunction

    function automatic void predict_char(logic [CHAR_W-1:0] c);
        logic [START_W-1:0] pos;
        logic               consumed;
        logic               restarted;
        longint unsigned    digit;
        pos       = char_pos;
        consumed  = 1'b0;
        restarted = 1'b0;
        token_beats.delete();
        case (mode)
            SCAN_IDENT: begin
                if (is_alpha(c)) begin
                    kw_hits = (tok_len < KW_SPAN) ? kw_advance(kw_hits, tok_len, c) : '0;
                    lengthen();
                    consumed = 1'b1;
                end else begin
                    close_ident();
                end
            end
            SCAN_NUMBER: begin
                if (is_numeral(c)) begin
                    digit = c - "0";
                    if (num_acc > (NUM_MAX - digit) / 10) begin
                        num_acc = '1;
                        sat     = 1'b1;
                    end else begin
                        num_acc = VALUE_W'(num_acc * 10 + digit);
                    end
                    lengthen();
                    consumed = 1'b1;
                end else if (is_alpha(c)) begin
                    add_token(TC_NUMBER, 1'b1, '0, sat, tok_len, tok_start, 1'b0);
                    begin_token(SCAN_IDENT, c, pos);
                    consumed = 1'b1;
                end else begin
                    add_token(TC_NUMBER, 1'b0, num_acc, sat, tok_len, tok_start, 1'b0);
                end
            end
            SCAN_COLON: begin
                if (c == "=") begin
                    add_token(TC_ASSIGN, 1'b0, '0, 1'b0, 2, tok_start, 1'b0);
                    mode     = SCAN_IDLE;
                    consumed = 1'b1;
                end else begin
                    add_token(TC_COLON, 1'b0, '0, 1'b0, 1, tok_start, 1'b0);
                end
            end
            SCAN_LESS: begin
                if (c == ">") begin
                    add_token(TC_NOT_EQ, 1'b0, '0, 1'b0, 2, tok_start, 1'b0);
                    mode     = SCAN_IDLE;
                    consumed = 1'b1;
                end else if (c == "=") begin
                    add_token(TC_LESS_EQ, 1'b0, '0, 1'b0, 2, tok_start, 1'b0);
                    mode     = SCAN_IDLE;
                    consumed = 1'b1;
                end else begin
                    add_token(TC_LESS, 1'b0, '0, 1'b0, 1, tok_start, 1'b0);
                end
            end
            SCAN_GREATER: begin
                if (c == "=") begin
                    add_token(TC_GREATER_EQ, 1'b0, '0, 1'b0, 2, tok_start, 1'b0);
                    mode     = SCAN_IDLE;
                    consumed = 1'b1;
                end else begin
                    add_token(TC_GREATER, 1'b0, '0, 1'b0, 1, tok_start, 1'b0);
                end
            end
            default: ;
        endcase
        if (!consumed) restarted = fresh_char(c, pos);
        if (!restarted) char_pos = pos + 1'b1;
        if (token_beats.size() > 0) token_beats[$].last = 1'b1;
        foreach (token_beats[i]) expected_tokens.push_back(token_beats[i]);
    endfunction

    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        if (!i_rst_n) begin
            clear_scan();
            expected_tokens.delete();
            fails   = 0;
            checked = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) predict_char(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                got.code  = i_m_tdata[4:0];
                got.value = i_m_tdata[36:5];
                got.ovf   = i_m_tdata[37];
                got.len   = i_m_tdata[43:38];
                got.start = i_m_tdata[59:44];
                got.err   = i_m_tuser[0];
                got.eot   = i_m_tuser[1];
                got.last  = i_m_tlast;
                if (expected_tokens.size() == 0) begin
                    if (fails < 10)
                        $display("token beat %0d arrived with nothing expected: %p", checked, got);
                    fails++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (want.code !== got.code || want.err !== got.err ||
                        want.value !== got.value || want.ovf !== got.ovf ||
                        want.len !== got.len || want.start !== got.start ||
                        want.eot !== got.eot || want.last !== got.last) begin
                        if (fails < 10)
                            $display("token beat %0d mismatch: expected %p, got %p",
                                     checked, want, got);
                        fails++;
                    end
                end
                checked++;
            end
        end
        o_fail_count     <= fails;
        o_tokens_pending <= expected_tokens.size();
        o_tokens_checked <= checked;
    end

endmodule

/* bench/tb_lexical_token_scanner_unit.sv */
module tb_lexical_token_scanner_unit;
    import lts_pkg::*;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 20;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [CHAR_W-1:0]   s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [TUSER_W-1:0]  m_tuser;
    logic                m_tlast;

    int fail_count;
    int tokens_pending;
    int tokens_checked;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   chars_sent     = 0;
    logic hold_go        = 1'b0;
    logic hold_off       = 1'b0;

    logic [CHAR_W-1:0] char_feed[$];

    int    idle_plan[4]  = '{0, 50, 0, 31};
    int    stall_plan[4] = '{0, 0, 50, 31};
    string kw_list[6]    = '{"for", "if", "then", "else", "while", "do"};
    string op_list[15]   = '{"+", "-", "*", "/", ":", ":=", "<", "<>", "<=", ">", ">=",
                             "=", ";", "(", ")"};

    lexical_token_scanner_unit u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    lexical_token_scanner_checker u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_m_tuser        (m_tuser),
        .i_m_tlast        (m_tlast),
        .o_fail_count     (fail_count),
        .o_tokens_pending (tokens_pending),
        .o_tokens_checked (tokens_checked)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (char_feed.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= char_feed.pop_front();
                chars_sent++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // hold the output side off long enough to back up the result queue
    initial begin
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic void feed_text(string s);
        for (int i = 0; i < s.len(); i++) char_feed.push_back(s[i]);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_letter();
        logic [CHAR_W-1:0] base;
        base = ($urandom_range(3) == 0) ? "A" : "a";
        return base + CHAR_W'($urandom_range(25));
    endfunction

    function automatic void add_random_token();
        int    pick;
        int    n;
        string s;
        pick = $urandom_range(99);
        if (pick < 15) begin
            s = kw_list[$urandom_range(5)];
            n = $urandom_range(3);
            if (n == 0) s = s.substr(0, s.len() - 2);
            feed_text(s);
            if (n == 1) char_feed.push_back(rand_letter());
        end else if (pick < 35) begin
            n = ($urandom_range(99) < 8) ? $urandom_range(30, 40) : $urandom_range(1, 7);
            repeat (n) char_feed.push_back(rand_letter());
        end else if (pick < 55) begin
            n = $urandom_range(99);
            if (n < 5) begin
                feed_text($urandom_range(1) ? "4294967295" : "4294967296");
            end else begin
                n = (n < 15) ? $urandom_range(9, 12) : $urandom_range(1, 4);
                repeat (n) char_feed.push_back("0" + CHAR_W'($urandom_range(9)));
            end
        end else if (pick < 80) begin
            feed_text(op_list[$urandom_range(14)]);
        end else if (pick < 88) begin
            char_feed.push_back(CHAR_W'($urandom_range(255)));
        end else if (pick < 90) begin
            feed_text("#");
        end
        case ($urandom_range(3))
            0:       ;
            1:       feed_text("\n");
            default: feed_text(" ");
        endcase
    endfunction

    task automatic drain();
        @(posedge clk);
        while (char_feed.size() != 0 || s_tvalid || tokens_pending != 0) @(posedge clk);
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        feed_text("for:i:=9<>x1<(=)+-*/>=>;7q");
        char_feed.push_back(8'hFF);
        char_feed.push_back(8'h00);
        feed_text("#");
        drain();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            if (p == 0) hold_go = 1'b1;
            while (char_feed.size() < ITEMS_PER_PHASE) add_random_token();
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Scanned %0d characters: directed operators and keywords, then random text",
                 chars_sent);
        $display("under four valid/ready mixes and one long output hold; %0d token beats checked",
                 tokens_checked);
        if (fail_count == 0 && tokens_pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/lts_pkg.sv
src/lexical_token_scanner_unit.sv
bench/lexical_token_scanner_checker.sv
bench/tb_lexical_token_scanner_unit.sv
